// ===== design/fsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg: shared definitions for the frustum sphere classifier
// Widths, plane layout, verdict codes and the control structs that pass
// between the classifier front end and the result queue.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RAD_WIDTH    = COORD_WIDTH - 1;
    localparam int PLANE_COUNT  = 6;
    localparam int PLANE_IDX_W  = $clog2(PLANE_COUNT);
    localparam int FIELD_W      = 16;
    localparam int NORM_FRAC    = 14;
    localparam int PROD_W       = FIELD_W + COORD_WIDTH;
    localparam int OFS_W        = FIELD_W + NORM_FRAC;
    localparam int DIST_W       = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    localparam int DATA_W       = 64;
    localparam int ADDR_W       = $clog2(8 * PLANE_COUNT);
    localparam int ADDR_LSB     = 3;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W        = $clog2(QUEUE_DEPTH + 3);

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] d;
        logic signed [FIELD_W-1:0] nz;
        logic signed [FIELD_W-1:0] ny;
        logic signed [FIELD_W-1:0] nx;
    } plane_t;

    typedef plane_t [PLANE_COUNT-1:0] plane_arr_t;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } qwr_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

// ===== design/fsc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_regs: plane register file
// Holds the six packed frustum planes behind an APB-style port.
// ----------------------------------------------------------------------------
module fsc_regs
    import fsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output plane_arr_t        planes
);

    plane_arr_t             planes_reg;
    logic [PLANE_IDX_W-1:0] idx;
    logic                   idx_ok;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:ADDR_LSB];
    assign idx_ok = (idx < PLANE_IDX_W'(PLANE_COUNT));
    assign planes = planes_reg;
    assign prdata = idx_ok ? DATA_W'(planes_reg[idx]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && idx_ok)
        begin
            planes_reg[idx] <= plane_t'(pwdata);
        end
    end

endmodule

// ===== design/fsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_front: sphere classifier pipeline
// Stage one forms the eighteen normal-by-coordinate products; stage two sums
// each plane distance, compares it against the radius and merges the flags
// into a verdict that is written into the result queue.
// ----------------------------------------------------------------------------
module fsc_front
    import fsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [RAD_WIDTH-1:0]   radius,
    input  plane_arr_t                    planes,
    input  qstat_t                        qstat,
    output qwr_t                          qwr
);

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] px_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0] py_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0] pz_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0] px_next [PLANE_COUNT];
    logic signed [PROD_W-1:0] py_next [PLANE_COUNT];
    logic signed [PROD_W-1:0] pz_next [PLANE_COUNT];
    logic [RAD_WIDTH-1:0]     rad_reg;
    logic [PLANE_COUNT-1:0]   out_reg;
    logic [PLANE_COUNT-1:0]   isect_reg;
    logic [PLANE_COUNT-1:0]   out_next;
    logic [PLANE_COUNT-1:0]   isect_next;
    logic signed [DIST_W-1:0] r_pos;
    logic signed [DIST_W-1:0] r_neg;
    logic [OCC_W-1:0]         occupancy;
    logic                     accept;

    assign occupancy = OCC_W'(qstat.count) + OCC_W'(v1_reg) + OCC_W'(v2_reg);
    assign full      = (occupancy >= OCC_W'(QUEUE_DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            px_next[i] = planes[i].nx * center_x;
            py_next[i] = planes[i].ny * center_y;
            pz_next[i] = planes[i].nz * center_z;
        end
    end

    always_comb
    begin
        logic signed [DIST_W-1:0] plane_dist;
        r_pos = $signed({{(DIST_W - RAD_WIDTH - NORM_FRAC){1'b0}}, rad_reg,
                         {NORM_FRAC{1'b0}}});
        r_neg = -r_pos;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            plane_dist = DIST_W'(px_reg[i]) + DIST_W'(py_reg[i]) + DIST_W'(pz_reg[i])
                       + (DIST_W'(planes[i].d) <<< NORM_FRAC);
            out_next[i]   = (plane_dist < r_neg);
            isect_next[i] = (plane_dist < r_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            rad_reg <= radius;
        end
        if (v1_reg)
        begin
            out_reg   <= out_next;
            isect_reg <= isect_next;
        end
    end

    always_comb
    begin
        qwr.valid = v2_reg;
        if (|out_reg)
        begin
            qwr.verdict = VERDICT_OUTSIDE;
        end
        else if (|isect_reg)
        begin
            qwr.verdict = VERDICT_INTERSECT;
        end
        else
        begin
            qwr.verdict = VERDICT_INSIDE;
        end
    end

endmodule

// ===== design/fsc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_queue: result queue
// Short first-in first-out store of verdicts between the classifier and the
// result port, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fsc_queue
    import fsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qwr_t       qwr,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] verdict,
    output qstat_t     qstat
);

    verdict_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign empty       = (count_reg == '0);
    assign do_pop      = pop && !empty;
    assign verdict     = mem_reg[rd_ptr_reg];
    assign qstat.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (qwr.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!qwr.valid && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (qwr.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (qwr.valid)
        begin
            mem_reg[wr_ptr_reg] <= qwr.verdict;
        end
    end

endmodule

// ===== design/frustum_sphere_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_sphere_classifier: view frustum sphere culling
// Classifies each bounding sphere as inside, intersecting or outside six
// frustum planes held in 64-bit registers.
//
//   Channel   Handshake                 Word
//   input     push / full               center_x, center_y, center_z, radius
//   result    empty / pop               verdict
//   config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One sphere is accepted every cycle while full is low; its verdict reaches
// the result queue after the multiply stage and the sum-and-compare stage.
// The result queue holds four verdicts, and full rises when the queue and
// the two pipeline stages together hold four words.
// Reset clears all planes to zero and empties the queue.
// ----------------------------------------------------------------------------
module frustum_sphere_classifier
    import fsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [RAD_WIDTH-1:0]   radius,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    verdict,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    plane_arr_t planes;
    qwr_t       qwr;
    qstat_t     qstat;

    fsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    fsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .radius   (radius),
        .planes   (planes),
        .qstat    (qstat),
        .qwr      (qwr)
    );

    fsc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .qwr     (qwr),
        .pop     (pop),
        .empty   (empty),
        .verdict (verdict),
        .qstat   (qstat)
    );

`ifndef SYNTHESIS
    a_accept_reaches_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !full) |=> ##1 qwr.valid
    ) else $error("Accepted word did not reach the result queue.");

    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        qwr.valid |-> (qstat.count < QCNT_W'(QUEUE_DEPTH)) || (pop && !empty)
    ) else $error("Result queue written while full.");

    a_full_when_queue_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (qstat.count == QCNT_W'(QUEUE_DEPTH)) |-> full
    ) else $error("Input not stalled with the result queue full.");
`endif

endmodule

// ===== test/cull_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cull_checker: verdict prediction and comparison for the sphere classifier
// Watches the configuration port, the sphere input queue and the verdict
// output queue. It keeps its own copy of the six frustum planes and computes
// the expected verdict for every accepted sphere. Each popped verdict is
// checked against the oldest expected one. Mismatches and verdicts that
// nobody expected are counted and reported to the testbench top.
// ----------------------------------------------------------------------------
module cull_checker
    import fsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [RAD_WIDTH-1:0]   radius,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [1:0]                    verdict,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output int                            fail_count,
    output int                            open_verdicts
);

    localparam longint UNIT_SCALE = 64'sd1 <<< NORM_FRAC;

    plane_t   plane_regs [PLANE_COUNT];
    verdict_t verdict_q [$];
    verdict_t oldest;
    int       mismatches;
    int       slot;
    int       k;

    function automatic verdict_t classify_sphere(
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [COORD_WIDTH-1:0] pz,
        input logic        [RAD_WIDTH-1:0]   rad
    );
        longint   xl;
        longint   yl;
        longint   zl;
        longint   reach;
        longint   plane_dist;
        verdict_t result;
        int       i;
        xl = px;
        yl = py;
        zl = pz;
        reach = rad;
        reach = reach * UNIT_SCALE;
        result = VERDICT_INSIDE;
        for (i = 0; i < PLANE_COUNT; i++)
        begin
            plane_dist = longint'($signed(plane_regs[i].nx)) * xl
                       + longint'($signed(plane_regs[i].ny)) * yl
                       + longint'($signed(plane_regs[i].nz)) * zl
                       + longint'($signed(plane_regs[i].d)) * UNIT_SCALE;
            if (plane_dist < -reach)
            begin
                result = VERDICT_OUTSIDE;
                break;
            end
            if (plane_dist < reach)
                result = VERDICT_INTERSECT;
        end
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < PLANE_COUNT; k++)
                plane_regs[k] = '0;
            verdict_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict word, expected none, actual %0d",
                             $time, verdict);
                    mismatches++;
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (verdict !== oldest)
                    begin
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, oldest, verdict);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
                verdict_q.push_back(classify_sphere(center_x, center_y, center_z, radius));
            if (psel && penable && pwrite && pready)
            begin
                slot = int'(paddr >> ADDR_LSB);
                if (slot < PLANE_COUNT)
                    plane_regs[slot] = plane_t'(pwdata);
            end
        end
        fail_count    <= mismatches;
        open_verdicts <= verdict_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the frustum sphere classifier
// Drives spheres into the input queue and drains verdicts with random
// idle cycles on both sides. Plane registers are rewritten between phases,
// starting from the reset planes, a unit box with exact boundary cases,
// writes to unmapped slots and extreme register values, then random box
// frustums and fully random planes. The checker predicts each verdict and
// the top reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;
    import fsc_pkg::*;

    localparam int PLANE_TOP    = 0;
    localparam int PLANE_BOTTOM = 1;
    localparam int PLANE_LEFT   = 2;
    localparam int PLANE_RIGHT  = 3;
    localparam int PLANE_NEAR   = 4;
    localparam int PLANE_FAR    = 5;
    localparam int UNMAPPED_LO  = 6;
    localparam int UNMAPPED_HI  = 7;
    localparam int UNIT_NORMAL  = 16384;
    localparam int BOX_HALF     = 2560;
    localparam int CYCLE_LIMIT  = 200000;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [RAD_WIDTH-1:0]   radius;
    logic                          empty;
    logic                          pop;
    logic [1:0]                    verdict;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_W-1:0]             paddr;
    logic [DATA_W-1:0]             pwdata;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;

    int fail_count;
    int open_verdicts;
    int cycles;
    bit push_fast;
    bit pop_fast;
    int phase;
    int n;
    int k;
    int stall;

    frustum_sphere_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .radius   (radius),
        .empty    (empty),
        .pop      (pop),
        .verdict  (verdict),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cull_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius        (radius),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .open_verdicts (open_verdicts)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic plane_t make_plane(input int nx, input int ny, input int nz, input int d);
        plane_t p;
        p.nx = FIELD_W'(nx);
        p.ny = FIELD_W'(ny);
        p.nz = FIELD_W'(nz);
        p.d  = FIELD_W'(d);
        return p;
    endfunction

    task automatic write_plane(input int slot, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(slot << ADDR_LSB);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sphere(input int x, input int y, input int z, input int r);
        int gap;
        gap = push_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push     <= 1'b1;
        center_x <= COORD_WIDTH'(x);
        center_y <= COORD_WIDTH'(y);
        center_z <= COORD_WIDTH'(z);
        radius   <= RAD_WIDTH'(r);
        do @(posedge clk); while (full);
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (open_verdicts != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic box_frustum();
        int slot;
        int axis;
        int comp [3];
        for (slot = 0; slot < PLANE_COUNT; slot++)
        begin
            comp[0] = $urandom_range(0, 4000) - 2000;
            comp[1] = $urandom_range(0, 4000) - 2000;
            comp[2] = $urandom_range(0, 4000) - 2000;
            if (slot == PLANE_TOP || slot == PLANE_BOTTOM)
                axis = 1;
            else if (slot == PLANE_LEFT || slot == PLANE_RIGHT)
                axis = 0;
            else
                axis = 2;
            comp[axis] = $urandom_range(0, 1) ? UNIT_NORMAL : $urandom_range(12000, UNIT_NORMAL);
            if (slot == PLANE_TOP || slot == PLANE_RIGHT || slot == PLANE_FAR)
                comp[axis] = -comp[axis];
            write_plane(slot, make_plane(comp[0], comp[1], comp[2],
                                         $urandom_range(0, 12000) - 1000));
        end
    endtask

    initial
    begin
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = pop_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        center_x  = '0;
        center_y  = '0;
        center_z  = '0;
        radius    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cycles    = 0;
        push_fast = 1'b0;
        pop_fast  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Planes at reset: every distance is zero.
        send_sphere(0, 0, 0, 0);
        send_sphere(32767, -32768, 32767, 32767);
        send_sphere(-32768, 32767, -32768, 0);
        send_sphere(16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA);
        settle();

        write_plane(PLANE_TOP,    make_plane(0, -UNIT_NORMAL, 0, BOX_HALF));
        write_plane(PLANE_BOTTOM, make_plane(0, UNIT_NORMAL, 0, BOX_HALF));
        write_plane(PLANE_LEFT,   make_plane(UNIT_NORMAL, 0, 0, BOX_HALF));
        write_plane(PLANE_RIGHT,  make_plane(-UNIT_NORMAL, 0, 0, BOX_HALF));
        write_plane(PLANE_NEAR,   make_plane(0, 0, UNIT_NORMAL, BOX_HALF));
        write_plane(PLANE_FAR,    make_plane(0, 0, -UNIT_NORMAL, BOX_HALF));

        // Distances that land exactly on the radius and on minus the radius.
        send_sphere(0, 0, 0, 0);
        send_sphere(0, 0, 0, BOX_HALF);
        send_sphere(0, 0, 0, BOX_HALF + 1);
        send_sphere(-2 * BOX_HALF, 0, 0, BOX_HALF);
        send_sphere(-2 * BOX_HALF - 1, 0, 0, BOX_HALF);
        send_sphere(BOX_HALF, 0, 0, 0);
        send_sphere(BOX_HALF + 1, 0, 0, 0);
        send_sphere(32767, 32767, 32767, 32767);
        send_sphere(-32768, -32768, -32768, 32767);
        settle();

        // Writes to slots past the last plane must leave the planes alone.
        write_plane(UNMAPPED_LO, 64'hFFFF_0000_8000_7FFF);
        write_plane(UNMAPPED_HI, 64'h8000_8000_8000_8000);
        send_sphere(100, -100, 50, 200);
        send_sphere(0, BOX_HALF + 1, 0, 0);
        settle();

        for (k = 0; k < PLANE_COUNT; k++)
            write_plane(k, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sphere(0, 0, 0, 0);
        send_sphere(32767, 32767, 32767, 1);
        send_sphere(-32768, -32768, -32768, 32767);
        settle();
        for (k = 0; k < PLANE_COUNT; k++)
            write_plane(k, 64'h8000_8000_8000_8000);
        send_sphere(-32768, -32768, -32768, 0);
        send_sphere(32767, 32767, 32767, 32767);
        send_sphere(0, 0, 0, 32767);
        settle();
        for (k = 0; k < PLANE_COUNT; k++)
            write_plane(k, 64'h7FFF_7FFF_7FFF_7FFF);
        send_sphere(-32768, -32768, -32768, 32767);
        send_sphere(32767, 32767, 32767, 0);
        send_sphere(-32768, 0, 0, 0);

        for (phase = 0; phase < 8; phase++)
        begin
            settle();
            push_fast = (phase % 3 == 1);
            pop_fast  = (phase % 4 == 2);
            if (phase == 5)
            begin
                for (k = 0; k < PLANE_COUNT; k++)
                    write_plane(k, {$urandom, $urandom});
            end
            else
                box_frustum();
            for (n = 0; n < 80; n++)
            begin
                if (phase == 3 && n == 40)
                    settle();
                if (n == 60)
                    push_fast = !push_fast;
                if ($urandom_range(0, 4) == 0)
                    send_sphere($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 32767));
                else
                    send_sphere($urandom_range(0, 24000) - 12000,
                                $urandom_range(0, 24000) - 12000,
                                $urandom_range(0, 24000) - 12000,
                                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6000));
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (open_verdicts != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && open_verdicts == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
